### src/hsp_pkg.sv
// Shared types and constants for the HTTP status header parser.
package hsp_pkg;

    // Input transaction payload
    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } in_item_t;

    // Result transaction payload
    typedef struct packed {
        logic [1:0]  outcome;
        logic [15:0] status_code;
    } out_item_t;

    // Input command codes
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_CLOSE = 1'b1;

    // Result outcome codes
    typedef enum logic [1:0] {
        OUTCOME_OK        = 2'd0,
        OUTCOME_BAD_CODE  = 2'd1,
        OUTCOME_TOO_LONG  = 2'd2,
        OUTCOME_CONN_LOST = 2'd3
    } outcome_t;

    // Number scanner phases
    typedef enum logic [1:0] {
        NUM_SKIP_WS = 2'd0,
        NUM_SIGN    = 2'd1,
        NUM_DIGITS  = 2'd2,
        NUM_STOP    = 2'd3
    } num_phase_t;

    // Classified item passed from front to back
    typedef struct packed {
        logic       closed;
        logic       newline;
        logic       space;
        logic       white;
        logic       plus;
        logic       minus;
        logic       digit;
        logic [3:0] digit_val;
        logic       nul;
        logic [3:0] prefix_hit;
    } byte_class_t;

    localparam logic [15:0] STATUS_OK       = 16'd200;
    localparam logic [15:0] STATUS_FAIL     = 16'd404;
    localparam logic [7:0]  MAX_LINES_RESET = 8'd20;
    localparam logic [2:0]  POS_SAT         = 3'd7;
    localparam logic [2:0]  PREFIX_LEN      = 3'd4;
    localparam int          QUEUE_DEPTH     = 2;

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    // Expected bytes of the status line prefix, position 0 first
    localparam logic [7:0] PREFIX_TEXT [4] = '{8'h48, 8'h54, 8'h54, 8'h50};

endpackage

### src/http_status_header_parser_unit.sv
// HTTP status header parser: front classifier, two-entry queue, back parser.
// A byte is stored in the queue; its result then goes to the result register.
// Throughput: one byte per cycle unless the queue is full or a result waits.
// The two-entry queue and the result register let input and output stall separately.
// Reset (rst_n low, asynchronous) empties the queue, clears the result and parser
// state, and sets max_lines to 20.
module http_status_header_parser_unit
    import hsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data
);

    logic        q_full;
    logic        q_push;
    logic        q_pop;
    logic        q_valid;
    byte_class_t q_in_item;
    byte_class_t q_out_item;

    // Classify incoming bytes
    hsp_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in_item)
    );

    // Decouple front and back
    hsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (q_out_item)
    );

    // Parse lines and hold results
    hsp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_item      (q_out_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    // A successful header always reports status 200
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.outcome == OUTCOME_OK) |-> out_data.status_code == STATUS_OK)
        else $error("ok outcome without status 200");

    // Line limit and lost connection always report 404
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((out_data.outcome == OUTCOME_TOO_LONG) ||
                      (out_data.outcome == OUTCOME_CONN_LOST))
        |-> out_data.status_code == STATUS_FAIL)
        else $error("failure outcome without status 404");

    // An accepted transaction is queued for the back end on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> q_valid)
        else $error("accepted transaction missing from queue");

    // The back end never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

### src/hsp_front.sv
// Front end: accepts input transactions and classifies each byte.
module hsp_front
    import hsp_pkg::*;
(
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    input  logic        q_full,
    output logic        q_push,
    output byte_class_t q_item
);

    logic [7:0] b;

    // Accept whenever the queue has room
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign b        = in_data.data_byte;

    // Classify the byte against every character group the parser uses
    always_comb
    begin
        q_item.closed    = (in_data.command == CMD_CLOSE);
        q_item.newline   = (b == CHAR_NL);
        q_item.space     = (b == CHAR_SPACE);
        q_item.white     = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
        q_item.plus      = (b == CHAR_PLUS);
        q_item.minus     = (b == CHAR_MINUS);
        q_item.digit     = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        q_item.digit_val = b[3:0];
        q_item.nul       = (b == CHAR_NUL);
        for (int i = 0; i < 4; i++)
        begin
            q_item.prefix_hit[i] = (b == PREFIX_TEXT[i]);
        end
    end

endmodule

### src/hsp_queue.sv
// Two-entry queue of classified items between front and back.
module hsp_queue
    import hsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  byte_class_t push_item,
    output logic        full,
    input  logic        pop,
    output logic        valid,
    output byte_class_t pop_item
);

    byte_class_t mem [QUEUE_DEPTH];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full     = (count_reg == 2'(QUEUE_DEPTH));
    assign valid    = (count_reg != 2'd0);
    assign pop_item = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### src/hsp_back.sv
// Back end: line tracking, status scanning and the result register.
module hsp_back
    import hsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        q_valid,
    input  byte_class_t q_item,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);

    logic [7:0]  max_lines_reg;
    logic [2:0]  line_pos_reg;
    logic [2:0]  line_pos_next;
    logic        prefix_match_reg;
    logic        prefix_match_next;
    logic        space_seen_reg;
    logic        space_seen_next;
    num_phase_t  phase_reg;
    num_phase_t  phase_next;
    logic        negative_reg;
    logic        negative_next;
    logic [15:0] status_reg;
    logic [15:0] status_next;
    logic [7:0]  line_count_reg;
    logic [7:0]  line_count_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_data_reg;
    out_item_t   out_data_next;

    logic        advance;
    logic        emit;
    outcome_t    emit_outcome;
    logic [15:0] emit_code;
    logic [7:0]  count_inc;
    logic [15:0] signed_status;
    logic [15:0] status_times_ten;

    // Process one queued transaction whenever the result slot can take a result
    assign advance   = q_valid && (!out_valid_reg || out_ready);
    assign q_pop     = advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign count_inc        = line_count_reg + 8'd1;
    assign signed_status    = negative_reg ? (16'd0 - status_reg) : status_reg;
    assign status_times_ten = {status_reg[12:0], 3'b000} + {status_reg[14:0], 1'b0};

    // Parser next state
    always_comb
    begin
        line_pos_next     = line_pos_reg;
        prefix_match_next = prefix_match_reg;
        space_seen_next   = space_seen_reg;
        phase_next        = phase_reg;
        negative_next     = negative_reg;
        status_next       = status_reg;
        line_count_next   = line_count_reg;
        emit              = 1'b0;
        emit_outcome      = OUTCOME_OK;
        emit_code         = STATUS_OK;

        if (q_item.closed)
        begin
            emit         = 1'b1;
            emit_outcome = OUTCOME_CONN_LOST;
            emit_code    = STATUS_FAIL;
        end
        else if (q_item.newline)
        begin
            line_count_next = count_inc;
            if (count_inc >= max_lines_reg)
            begin
                emit         = 1'b1;
                emit_outcome = OUTCOME_TOO_LONG;
                emit_code    = STATUS_FAIL;
            end
            else if (prefix_match_reg && (line_pos_reg >= PREFIX_LEN))
            begin
                if (space_seen_reg)
                begin
                    status_next = signed_status;
                    if (signed_status != STATUS_OK)
                    begin
                        emit         = 1'b1;
                        emit_outcome = OUTCOME_BAD_CODE;
                        emit_code    = signed_status;
                    end
                end
            end
            else if (line_pos_reg == 3'd1)
            begin
                emit = 1'b1;
                if (status_reg == STATUS_OK)
                begin
                    emit_outcome = OUTCOME_OK;
                    emit_code    = STATUS_OK;
                end
                else
                begin
                    emit_outcome = OUTCOME_BAD_CODE;
                    emit_code    = STATUS_FAIL;
                end
            end
            // Start a new line
            line_pos_next     = 3'd0;
            prefix_match_next = 1'b1;
            space_seen_next   = 1'b0;
            phase_next        = NUM_SKIP_WS;
            negative_next     = 1'b0;
        end
        else
        begin
            if (line_pos_reg < PREFIX_LEN)
            begin
                if (!q_item.prefix_hit[line_pos_reg[1:0]])
                begin
                    prefix_match_next = 1'b0;
                end
            end
            else if (prefix_match_reg)
            begin
                if (!space_seen_reg)
                begin
                    if (q_item.space)
                    begin
                        space_seen_next = 1'b1;
                        status_next     = 16'd0;
                        phase_next      = NUM_SKIP_WS;
                        negative_next   = 1'b0;
                    end
                    else if (q_item.nul)
                    begin
                        prefix_match_next = 1'b0;
                    end
                end
                else
                begin
                    // Scan the number by atoi rules
                    case (phase_reg)
                        NUM_SKIP_WS:
                        begin
                            if (q_item.white)
                            begin
                                phase_next = NUM_SKIP_WS;
                            end
                            else if (q_item.plus)
                            begin
                                phase_next = NUM_SIGN;
                            end
                            else if (q_item.minus)
                            begin
                                negative_next = 1'b1;
                                phase_next    = NUM_SIGN;
                            end
                            else if (q_item.digit)
                            begin
                                status_next = status_times_ten + {12'd0, q_item.digit_val};
                                phase_next  = NUM_DIGITS;
                            end
                            else
                            begin
                                phase_next = NUM_STOP;
                            end
                        end
                        NUM_SIGN, NUM_DIGITS:
                        begin
                            if (q_item.digit)
                            begin
                                status_next = status_times_ten + {12'd0, q_item.digit_val};
                                phase_next  = NUM_DIGITS;
                            end
                            else
                            begin
                                phase_next = NUM_STOP;
                            end
                        end
                        default:
                        begin
                            phase_next = NUM_STOP;
                        end
                    endcase
                end
            end
            if (line_pos_reg != POS_SAT)
            begin
                line_pos_next = line_pos_reg + 3'd1;
            end
        end

        // Re-arm after any result
        if (emit)
        begin
            line_pos_next     = 3'd0;
            prefix_match_next = 1'b1;
            space_seen_next   = 1'b0;
            phase_next        = NUM_SKIP_WS;
            negative_next     = 1'b0;
            status_next       = 16'd0;
            line_count_next   = 8'd0;
        end
    end

    // Result register: load on a result, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (advance && emit)
        begin
            out_valid_next            = 1'b1;
            out_data_next.outcome     = emit_outcome;
            out_data_next.status_code = emit_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_lines_reg    <= MAX_LINES_RESET;
            line_pos_reg     <= 3'd0;
            prefix_match_reg <= 1'b1;
            space_seen_reg   <= 1'b0;
            phase_reg        <= NUM_SKIP_WS;
            negative_reg     <= 1'b0;
            status_reg       <= 16'd0;
            line_count_reg   <= 8'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_lines_reg <= cfg_wr_data;
            end
            if (advance)
            begin
                line_pos_reg     <= line_pos_next;
                prefix_match_reg <= prefix_match_next;
                space_seen_reg   <= space_seen_next;
                phase_reg        <= phase_next;
                negative_reg     <= negative_next;
                status_reg       <= status_next;
                line_count_reg   <= line_count_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule
